### rtl/core/olem_pkg.sv
// Package for the ordered list extract-min block.
// Holds operation and status codes and the controller/datapath command
// and status structs. Depends on nothing.
package olem_pkg;

  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan;
    logic shift_init;
    logic shift;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic idx_end;
    logic rd_vld;
    logic out_busy;
  } stat_t;

endpackage

### rtl/core/olem_ctrl.sv
// Controller state machine for the ordered list extract-min block.
// Sequences accept, minimum scan, gap shift and result hand-off.
// Depends on olem_pkg.
module olem_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic           s_func,
  input  olem_pkg::stat_t st,
  output olem_pkg::cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (s_func == olem_pkg::FUNC_EXTRACT && !st.empty) begin
            cmd.scan_init = 1'b1;
            state_next = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (st.idx_end && !st.rd_vld) begin
          cmd.shift_init = 1'b1;
          state_next = S_SHIFT;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_SHIFT: begin
        if (st.idx_end && !st.rd_vld) begin
          state_next = S_DONE;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/core/olem_dpath.sv
// Datapath for the ordered list extract-min block: entry memory, count,
// scan index, running minimum and output register.
// Depends on olem_pkg.
module olem_dpath #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  olem_pkg::cmd_t      cmd,
  output olem_pkg::stat_t     st,
  input  logic                s_func,
  input  logic signed [31:0]  s_value,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [1:0]          m_status,
  output logic signed [31:0]  m_min_value,
  output logic [4:0]          m_count_after
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic signed [31:0] mem [0:DEPTH-1];

  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      rd_idx;
  logic               rd_vld;
  logic signed [31:0] rd_data;
  logic [CW-1:0]      best_idx;
  logic signed [31:0] best_val;
  logic               func_r;
  logic signed [31:0] value_r;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_data;
  logic [CW-1:0]      shift_dst;
  logic               full;
  logic               issue;

  assign full      = (count >= DEPTH_C);
  assign shift_dst = rd_idx - 1'b1;
  assign issue     = (cmd.scan || cmd.shift) && (idx < count);

  assign st.empty    = (count == '0);
  assign st.idx_end  = (idx >= count);
  assign st.rd_vld   = rd_vld;
  assign st.out_busy = m_tvalid && !m_tready;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = value_r;
    if (cmd.finish && func_r == olem_pkg::FUNC_INSERT && !full) begin
      wr_en = 1'b1;
    end else if (cmd.shift && rd_vld) begin
      wr_en   = 1'b1;
      wr_addr = shift_dst[AW-1:0];
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data <= mem[idx[AW-1:0]];
      rd_idx  <= idx;
    end
    if (cmd.load) begin
      func_r  <= s_func;
      value_r <= s_value;
    end
    if (cmd.scan && rd_vld) begin
      if (rd_idx == '0 || rd_data < best_val) begin
        best_val <= rd_data;
        best_idx <= rd_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (cmd.scan_init) begin
        idx <= '0;
      end else if (cmd.shift_init) begin
        idx <= best_idx + 1'b1;
      end else if (issue) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
        if (func_r == olem_pkg::FUNC_INSERT) begin
          m_min_value <= '0;
          if (full) begin
            m_status      <= olem_pkg::ST_FULL;
            m_count_after <= 5'(count);
          end else begin
            m_status      <= olem_pkg::ST_OK;
            count         <= count + 1'b1;
            m_count_after <= 5'(count + 1'b1);
          end
        end else begin
          if (count == '0) begin
            m_status      <= olem_pkg::ST_EMPTY;
            m_min_value   <= '0;
            m_count_after <= 5'(count);
          end else begin
            m_status      <= olem_pkg::ST_OK;
            m_min_value   <= best_val;
            count         <= count - 1'b1;
            m_count_after <= 5'(count - 1'b1);
          end
        end
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count above depth");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> rd_idx < count)
    else $error("read of an entry beyond the count");

  a_extract_dec: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && func_r == olem_pkg::FUNC_EXTRACT && count != '0
    |=> count == $past(count) - 1'b1)
    else $error("extract did not remove one entry");

endmodule

### rtl/core/ordered_list_extract_min.sv
// Top level of the ordered list extract-min block.
// Instantiates olem_ctrl and olem_dpath; depends on olem_pkg.
//
// The input channel carries one request per item: s_tuser selects the
// operation (insert at the tail or extract the smallest entry) and s_tdata
// carries the signed value to insert. Each request yields exactly one item
// on the output channel: m_tuser holds the status (ok, empty, full), and
// m_tdata holds the extracted value and the entry count after the request.
// Requests are handled one at a time. An insert, or an extract of an empty
// list, goes from the accept straight to the done state. An extract scans every
// entry for the minimum and then shifts the entries above it down to close
// the gap, through the single memory read port that is used once per entry
// for the scan and once per moved entry for the shift. The next item is
// accepted from the cycle after the result is written.
// A finished result sits in an output register, so a stalled receiver only
// blocks the block once the next result is ready to be written.
// Reset empties the list and drops any pending result; stored values are
// not cleared since entries above the count are never read.
module ordered_list_extract_min #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [31:0] value
  input  logic [0:0]  s_tuser,  // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // [31:0] min_value, [36:32] count_after, [39:37] zero
  output logic [1:0]  m_tuser   // [1:0] status
);

  olem_pkg::cmd_t  cmd;
  olem_pkg::stat_t st;

  logic signed [31:0] min_value;
  logic [4:0]         count_after;

  olem_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_func   (s_tuser[0]),
    .st       (st),
    .cmd      (cmd)
  );

  olem_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .s_func        (s_tuser[0]),
    .s_value       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_status      (m_tuser),
    .m_min_value   (min_value),
    .m_count_after (count_after)
  );

  assign m_tdata = {3'b000, count_after, min_value};

endmodule

### tb/tb.sv
// Self-checking bench for ordered_list_extract_min: directed table, then random requests.
// Checked against table rows or an in-bench list predictor; random idling on both sides.
// Depends on olem_pkg and the ordered_list_extract_min RTL.
`timescale 1ns / 100ps

module tb;

  localparam int LIST_DEPTH = 16;
  localparam int RAND_ITEMS = 1300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] min_value;
    logic [4:0]  count_after;
  } olem_res_t;

  typedef struct {
    logic      func;
    logic [31:0] value;
    logic      typed;
    olem_res_t want;
  } stim_row_t;

  typedef struct {
    logic      typed;
    olem_res_t want;
  } req_tag_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;

  logic signed [31:0] held_list[$];
  stim_row_t          dir_rows[$];
  req_tag_t           tag_q[$];
  olem_res_t          want_q[$];
  olem_res_t          pred_res, got_res, want_res;
  req_tag_t           acc_tag;
  int                 errors = 0;
  logic               calm = 1'b0;

  ordered_list_extract_min dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic olem_res_t olist_apply(logic func, logic [31:0] value);
    olem_res_t r;
    int        best;
    r = '{status: olem_pkg::ST_OK, min_value: '0, count_after: '0};
    if (func == olem_pkg::FUNC_INSERT) begin
      if (held_list.size() >= LIST_DEPTH) begin
        r.status = olem_pkg::ST_FULL;
      end else begin
        held_list.push_back(value);
      end
    end else begin
      if (held_list.size() == 0) begin
        r.status = olem_pkg::ST_EMPTY;
      end else begin
        best = 0;
        for (int i = 1; i < held_list.size(); i++) begin
          if (held_list[i] < held_list[best]) begin
            best = i;
          end
        end
        r.min_value = held_list[best];
        held_list.delete(best);
      end
    end
    r.count_after = 5'(held_list.size());
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [39:0] got, logic [39:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic add_row(logic func, logic [31:0] value, logic typed,
                         logic [1:0] st, logic [31:0] mv, logic [4:0] cnt);
    stim_row_t row;
    row.func  = func;
    row.value = value;
    row.typed = typed;
    row.want  = '{status: st, min_value: mv, count_after: cnt};
    dir_rows.push_back(row);
  endtask

  task automatic send_item(logic func, logic [31:0] value, logic typed, olem_res_t want);
    req_tag_t tag;
    while (!calm && $urandom_range(99) < 31) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    tag.typed = typed;
    tag.want  = want;
    tag_q.push_back(tag);
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= func;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(9);
    case (r)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3, 4: return 32'($signed($urandom_range(8)) - 4);
      default: return $urandom();
    endcase
  endfunction

  always @(posedge clk) begin
    m_tready <= rst ? 1'b0 : (calm || $urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        pred_res = olist_apply(s_tuser[0], s_tdata);
        acc_tag  = tag_q.pop_front();
        want_q.push_back(acc_tag.typed ? acc_tag.want : pred_res);
      end
      if (m_tvalid && m_tready) begin
        got_res = '{status: m_tuser, min_value: m_tdata[31:0], count_after: m_tdata[36:32]};
        if (want_q.size() == 0) begin
          note_mismatch("unexpected result", {m_tuser, m_tdata[37:0]}, '0);
        end else begin
          want_res = want_q.pop_front();
          if (got_res.status != want_res.status)
            note_mismatch("status", 40'(got_res.status), 40'(want_res.status));
          if (got_res.min_value != want_res.min_value)
            note_mismatch("min_value", 40'(got_res.min_value), 40'(want_res.min_value));
          if (got_res.count_after != want_res.count_after)
            note_mismatch("count_after", 40'(got_res.count_after),
                          40'(want_res.count_after));
          if (m_tdata[39:37] != 3'b000)
            note_mismatch("tdata pad", 40'(m_tdata[39:37]), '0);
        end
      end
    end
  end

  initial begin
    logic [31:0] fill_vals[16];
    olem_res_t   none;
    int          mode;
    int          ins_pct;
    logic        func;

    none = '{status: olem_pkg::ST_OK, min_value: '0, count_after: '0};
    fill_vals = '{32'd3, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000,
                  32'd2, 32'h8000_0000, 32'd5, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd9,
                  32'h0000_FFFF, 32'd4, 32'd3};

    add_row(olem_pkg::FUNC_EXTRACT, 32'h1234_5678, 1'b1, olem_pkg::ST_EMPTY, 32'd0, 5'd0);
    add_row(olem_pkg::FUNC_INSERT, 32'h7FFF_FFFF, 1'b1, olem_pkg::ST_OK, 32'd0, 5'd1);
    add_row(olem_pkg::FUNC_INSERT, 32'h8000_0000, 1'b1, olem_pkg::ST_OK, 32'd0, 5'd2);
    add_row(olem_pkg::FUNC_EXTRACT, 32'hFFFF_FFFF, 1'b1, olem_pkg::ST_OK, 32'h8000_0000,
            5'd1);
    add_row(olem_pkg::FUNC_EXTRACT, 32'd0, 1'b1, olem_pkg::ST_OK, 32'h7FFF_FFFF, 5'd0);
    add_row(olem_pkg::FUNC_EXTRACT, 32'd0, 1'b1, olem_pkg::ST_EMPTY, 32'd0, 5'd0);
    foreach (fill_vals[i]) begin
      add_row(olem_pkg::FUNC_INSERT, fill_vals[i], 1'b0, olem_pkg::ST_OK, 32'd0, 5'd0);
    end
    add_row(olem_pkg::FUNC_INSERT, 32'h5555_5555, 1'b1, olem_pkg::ST_FULL, 32'd0, 5'd16);
    add_row(olem_pkg::FUNC_EXTRACT, 32'd0, 1'b0, olem_pkg::ST_OK, 32'd0, 5'd0);
    add_row(olem_pkg::FUNC_EXTRACT, 32'd0, 1'b0, olem_pkg::ST_OK, 32'd0, 5'd0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].func, dir_rows[i].value,
                                    dir_rows[i].typed, dir_rows[i].want);

    ins_pct = 50;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 40 == 0) begin
        mode = $urandom_range(2);
        ins_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
      end
      calm = (n >= 500 && n < 750);
      func = ($urandom_range(99) < ins_pct) ? olem_pkg::FUNC_INSERT : olem_pkg::FUNC_EXTRACT;
      send_item(func, pick_value(), 1'b0, none);
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;

    while (tag_q.size() + want_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (want_q.size() != 0) note_mismatch("missing results", 40'(want_q.size()), '0);

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/olem_pkg.sv
rtl/core/olem_ctrl.sv
rtl/core/olem_dpath.sv
rtl/core/ordered_list_extract_min.sv
tb/tb.sv
